### src/positional_list_engine_assert.svh
// Assertion macros for the positional list engine.
// Included by the files that carry concurrent checks; needs no other file.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define PLE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("positional list engine: invariant violated");

// Antecedent in a cycle implies the consequent in the same cycle.
`define PLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional list engine: implication violated");

// Antecedent in a cycle implies the consequent in the next cycle.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list engine: next-cycle check violated");

`endif

### src/ple_pkg.sv
// Shared types and codes for the positional list engine.
// Used by positional_list_engine; depends on nothing.
package ple_pkg;

    // Fixed field widths of the request and result ports
    localparam int unsigned OP_W    = 2;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 7;

    // Request op codes
    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_UP    = 5'b00100,
        S_PLACE = 5'b01000,
        S_DN    = 5'b10000
    } t_state;

endpackage

### src/positional_list_engine.sv
// Positional list engine top level: request sequencer and result register.
// Depends on ple_pkg, ple_store and positional_list_engine_assert.svh.
//
// Usage:
//   A request (op, position, item_value) is taken at a clock edge where start
//   is high and busy is low. Each request yields one result on o_status,
//   o_read_value and o_item_count, valid for exactly one cycle with o_strobe.
//   The receiver cannot stall; results are never held back.
//   Path from accept to strobe:
//     refused request, op 3, insert at the tail : result registered at accept
//     read                                       : via S_READ
//     insert at position p with n entries held   : S_UP, then S_PLACE
//     remove at position p with n entries held   : S_DN shifts entries down
//   The shifting is set by the entry store: one read and one write port,
//   each entry moved goes through the read-then-write shift loop. busy is
//   high while a request is in progress; a new request may be taken in the
//   cycle its result shows.
//   Reset clears the count to zero and the sequencer to idle; the store
//   itself needs no clearing since only entries below the count are read.
`include "positional_list_engine_assert.svh"

module positional_list_engine #(
    parameter int unsigned CAPACITY  = 64,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ple_pkg::OP_W-1:0]         i_op,
    input  logic [ple_pkg::POS_W-1:0]        i_position,
    input  logic [ple_pkg::VALUE_W-1:0]      i_item_value,
    output logic                             o_strobe,
    output logic [ple_pkg::STAT_W-1:0]       o_status,
    output logic [ple_pkg::VALUE_W-1:0]      o_read_value,
    output logic [ple_pkg::COUNT_W-1:0]      o_item_count
);

    import ple_pkg::*;

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // Control registers
    t_state               r_state,   n_state;
    logic [CW-1:0]        r_count,   n_count;
    logic [AW-1:0]        r_rd_addr, n_rd_addr;
    logic                 r_strobe,  n_strobe;
    // Payload registers
    logic [AW-1:0]        r_pos,     n_pos;
    logic [WORD_BITS-1:0] r_value,   n_value;
    logic [WORD_BITS-1:0] r_word,    n_word;
    logic [STAT_W-1:0]    r_status,  n_status;
    logic [VALUE_W-1:0]   r_rval,    n_rval;

    // Store port signals
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_q;

    logic                 accept;
    logic                 shifting;
    logic [CMPW-1:0]      pos_ext;
    logic [CMPW-1:0]      cnt_ext;
    logic [AW-1:0]        last_addr;
    logic [WORD_BITS-1:0] word_now;

    ple_store #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign shifting  = (r_state == S_UP) || (r_state == S_DN);
    assign pos_ext   = CMPW'(i_position);
    assign cnt_ext   = CMPW'(r_count);
    assign last_addr = AW'(r_count - 1'b1);
    assign word_now  = (r_rd_addr == r_pos) ? mem_q : r_word;

    // Sequencer: range and full checks on accept, then a read or the read-then-write shift loop
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_addr = r_rd_addr;
        n_strobe  = 1'b0;
        n_pos     = r_pos;
        n_value   = r_value;
        n_word    = r_word;
        n_status  = r_status;
        n_rval    = r_rval;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_value;
        mem_raddr = r_rd_addr;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos   = AW'(i_position);
                    n_value = WORD_BITS'(i_item_value);
                    n_rval  = '0;
                    case (i_op)
                        OP_READ: begin
                            if (pos_ext >= cnt_ext) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                mem_raddr = AW'(i_position);
                                n_rd_addr = AW'(i_position);
                                n_state   = S_READ;
                            end
                        end
                        OP_INSERT: begin
                            if (pos_ext > cnt_ext) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else if (r_count == CAP_CNT) begin
                                n_strobe = 1'b1;
                                n_status = ST_FULL;
                            end else if (pos_ext == cnt_ext) begin
                                // Append at the tail: no entries to move
                                mem_we    = 1'b1;
                                mem_waddr = AW'(i_position);
                                mem_wdata = WORD_BITS'(i_item_value);
                                n_count   = r_count + 1'b1;
                                n_strobe  = 1'b1;
                                n_status  = ST_OK;
                            end else begin
                                mem_raddr = last_addr;
                                n_rd_addr = last_addr;
                                n_state   = S_UP;
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_ext >= cnt_ext) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                mem_raddr = AW'(i_position);
                                n_rd_addr = AW'(i_position);
                                n_state   = S_DN;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            S_READ: begin
                n_strobe = 1'b1;
                n_status = ST_OK;
                n_rval   = VALUE_W'(mem_q);
                n_state  = S_IDLE;
            end

            // Move entries up, walking down from the tail
            S_UP: begin
                mem_we    = 1'b1;
                mem_waddr = r_rd_addr + 1'b1;
                mem_wdata = mem_q;
                if (r_rd_addr == r_pos) begin
                    n_state = S_PLACE;
                end else begin
                    mem_raddr = r_rd_addr - 1'b1;
                    n_rd_addr = r_rd_addr - 1'b1;
                end
            end

            S_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_value;
                n_count   = r_count + 1'b1;
                n_strobe  = 1'b1;
                n_status  = ST_OK;
                n_state   = S_IDLE;
            end

            // Capture the removed word, then move entries down toward it
            S_DN: begin
                if (r_rd_addr == r_pos) begin
                    n_word = mem_q;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rd_addr - 1'b1;
                    mem_wdata = mem_q;
                end
                if (r_rd_addr == last_addr) begin
                    n_count  = r_count - 1'b1;
                    n_strobe = 1'b1;
                    n_status = ST_OK;
                    n_rval   = VALUE_W'(word_now);
                    n_state  = S_IDLE;
                end else begin
                    mem_raddr = r_rd_addr + 1'b1;
                    n_rd_addr = r_rd_addr + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_addr <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_addr <= n_rd_addr;
            r_strobe  <= n_strobe;
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_value  <= n_value;
        r_word   <= n_word;
        r_status <= n_status;
        r_rval   <= n_rval;
    end

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_read_value = r_rval;
    assign o_item_count = COUNT_W'(r_count);

    // Checks
    `PLE_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CAP_CNT)
    `PLE_ASSERT_IMPLY(a_strobe_idle, i_clk, i_rst_n, r_strobe, r_state == S_IDLE)
    `PLE_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, accept, r_strobe || busy)
    `PLE_ASSERT_IMPLY(a_shift_addr, i_clk, i_rst_n, shifting, CW'(r_rd_addr) < r_count)

endmodule

### src/ple_store.sv
// Entry store: single write port, single read port, registered read data.
// Standalone; instantiated by positional_list_engine.
module ple_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
